// ----- rtl/core/fra_pkg.sv -----
// Package: widths, commands, status codes for fraction_arith_reduce.
`default_nettype none
package fra_pkg;
  localparam int OperandWidth = 16;
  localparam int OutBits = 33;
  localparam logic [1:0] CMD_MUL = 2'd0;
  localparam logic [1:0] CMD_DIV = 2'd1;
  localparam logic [1:0] CMD_ADD = 2'd2;
  localparam logic [1:0] CMD_SUB = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO_IN = 2'd1;
  localparam logic [1:0] ST_ZERO_RES = 2'd2;
  localparam int OutBytes = (2 + 4 * OutBits + 1 + 7) / 8;
endpackage
`default_nettype wire

// ----- rtl/core/fraction_arith_reduce.sv -----
// Top level: fraction cross products, Euclid gcd and reduction.
//  channel | dir | tdata fields (low bit first)
//  s_axis  | in  | command, num_a, den_a, num_b, den_b
//  m_axis  | out | status, raw_num, raw_den, red_num, red_den, was_reduced
// Products are formed one per cycle on a single 2W-bit multiplier.
// Each gcd step and both final divisions run on one 64-bit serial divider.
// Reset clears control only. s_axis_tready is low from accept until the
// result is taken; the result register holds while m_axis_tready is low.
`default_nettype none
module fraction_arith_reduce #(
  parameter int OPERAND_WIDTH = fra_pkg::OperandWidth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // command, num_a, den_a, num_b, den_b
  input  wire logic [((2 + 4 * OPERAND_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // status, raw_numerator, raw_denominator, reduced_numerator,
  // reduced_denominator, was_reduced
  output logic [fra_pkg::OutBytes * 8 - 1:0] m_axis_tdata
);
  localparam int W = OPERAND_WIDTH;
  localparam int P = 2 * W + 1;
  localparam int DW = 64;
  localparam int OB = fra_pkg::OutBits;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_GCD = 3'd2;
  localparam logic [2:0] S_DIVN = 3'd3;
  localparam logic [2:0] S_DIVD = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;
  localparam logic [2:0] S_WAIT = 3'd6;

  logic [2:0] st_q, st_d;
  logic [1:0] step_q, step_d;
  logic [1:0] cmd_q;
  logic signed [W-1:0] na_q, da_q, nb_q, db_q;
  logic signed [P-1:0] rn_q, rd_q;
  logic [DW-1:0] ga_q, gb_q, qn_q;
  logic pend_q;
  logic [1:0] stat_q;
  logic [OB-1:0] onum_q, oden_q, oqn_q, oqd_q;
  logic ored_q, ovalid_q;
  logic signed [W-1:0] ma, mb;
  logic signed [2*W-1:0] prod;
  logic div_start, div_done;
  logic [DW-1:0] div_a, div_b, div_q, div_r;
  logic [DW-1:0] rn_mag, rd_mag;
  logic [DW-1:0] qsn, qsd;

  assign prod = ma * mb;
  assign rn_mag = rn_q[P-1] ? DW'(-rn_q) : DW'(rn_q);
  assign rd_mag = rd_q[P-1] ? DW'(-rd_q) : DW'(rd_q);
  assign qsn = rn_q[P-1] ? -qn_q : qn_q;
  assign qsd = rd_q[P-1] ? -div_q : div_q;

  always_comb begin
    ma = na_q; mb = nb_q;
    case (step_q)
      2'd0: begin
        ma = na_q;
        mb = (cmd_q == fra_pkg::CMD_MUL) ? nb_q : db_q;
      end
      2'd1: begin
        ma = da_q;
        mb = (cmd_q == fra_pkg::CMD_DIV) ? nb_q : db_q;
      end
      2'd2: begin ma = da_q; mb = nb_q; end
      default: begin ma = na_q; mb = nb_q; end
    endcase
  end

  fra_divu #(.W(DW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_a),
    .divisor_i(div_b), .done_o(div_done), .quot_o(div_q), .rem_o(div_r)
  );

  always_comb begin
    st_d = st_q; step_d = step_q;
    div_start = 1'b0; div_a = ga_q; div_b = gb_q;
    case (st_q)
      S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
        st_d = S_MUL; step_d = 2'd0;
      end
      S_MUL: begin
        step_d = step_q + 1'b1;
        if (step_q == 2'd2) st_d = S_GCD;
      end
      S_GCD: if (!pend_q) begin
        if (rd_q == '0) st_d = S_OUT;
        else if (gb_q == '0) begin
          st_d = S_DIVN; div_start = 1'b1; div_a = rn_mag; div_b = ga_q;
        end else div_start = 1'b1;
      end else if (div_done) st_d = S_GCD;
      S_DIVN: if (!pend_q) begin
        div_start = 1'b1; div_a = rd_mag; div_b = ga_q; st_d = S_DIVD;
      end
      S_DIVD: if (div_done) st_d = S_OUT;
      S_OUT: st_d = S_WAIT;
      S_WAIT: if (m_axis_tready) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; step_q <= '0; pend_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d; step_q <= step_d;
      if (div_start) pend_q <= 1'b1;
      else if (div_done) pend_q <= 1'b0;
      if (st_q == S_OUT) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && s_axis_tvalid) begin
      cmd_q <= s_axis_tdata[1:0];
      na_q <= s_axis_tdata[2 +: W];
      da_q <= s_axis_tdata[2 + W +: W];
      nb_q <= s_axis_tdata[2 + 2 * W +: W];
      db_q <= s_axis_tdata[2 + 3 * W +: W];
    end
    if (st_q == S_MUL) begin
      case (step_q)
        2'd0: rn_q <= P'(prod);
        2'd1: rd_q <= P'(prod);
        2'd2: begin
          if (cmd_q == fra_pkg::CMD_ADD) rn_q <= rn_q + P'(prod);
          else if (cmd_q == fra_pkg::CMD_SUB) rn_q <= rn_q - P'(prod);
        end
        default: begin end
      endcase
      if (step_q == 2'd2) begin
        ga_q <= (cmd_q[1]) ? ((rn_q + (cmd_q[0] ? -P'(prod) : P'(prod))) < 0 ?
                  DW'(-(rn_q + (cmd_q[0] ? -P'(prod) : P'(prod)))) :
                  DW'(rn_q + (cmd_q[0] ? -P'(prod) : P'(prod)))) : rn_mag;
        gb_q <= rd_mag;
      end
    end
    if (st_q == S_GCD && pend_q && div_done) begin
      ga_q <= gb_q; gb_q <= div_r;
    end
    if (st_q == S_DIVN && pend_q && div_done) qn_q <= div_q;
    if (st_q == S_OUT || (st_q == S_DIVD && div_done)) begin
      if (da_q == '0 || db_q == '0) begin
        stat_q <= fra_pkg::ST_ZERO_IN;
        onum_q <= '0; oden_q <= '0; oqn_q <= '0; oqd_q <= '0; ored_q <= 1'b0;
      end else begin
        onum_q <= OB'(rn_q); oden_q <= OB'(rd_q);
        if (rd_q == '0) begin
          stat_q <= fra_pkg::ST_ZERO_RES;
          oqn_q <= '0; oqd_q <= '0; ored_q <= 1'b0;
        end else if (st_q == S_DIVD) begin
          stat_q <= fra_pkg::ST_OK;
          oqn_q <= OB'(qsn); oqd_q <= OB'(qsd); ored_q <= (ga_q > DW'(1));
        end
      end
    end
  end

  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {{(fra_pkg::OutBytes * 8 - 4 * OB - 3){1'b0}},
                         ored_q, oqd_q, oqn_q, oden_q, onum_q, stat_q};
endmodule
`default_nettype wire

// ----- rtl/core/fra_divu.sv -----
// Shared restoring divider: one quotient bit per cycle, unsigned.
`default_nettype none
module fra_divu #(
  parameter int W = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quot_o,
  output logic [W-1:0]      rem_o
);
  localparam int CW = $clog2(W + 1);
  logic [W-1:0] q_q, q_d, r_q, r_d, d_q, d_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [W:0] sh, diff;

  always_comb begin
    sh = {r_q, q_q[W-1]};
    diff = sh - {1'b0, d_q};
    q_d = q_q; r_d = r_q; d_d = d_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      q_d = dividend_i; r_d = '0; d_d = divisor_i;
      cnt_d = CW'(W); busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[W]) begin
        r_d = diff[W-1:0]; q_d = {q_q[W-2:0], 1'b1};
      end else begin
        r_d = sh[W-1:0]; q_d = {q_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d; d_q <= d_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o = r_q;
endmodule
`default_nettype wire
